FILE: rtl/kpg_pkg.sv
// Package for the key proximity grid: sizes, register indexes, opcodes and types.
// Used by key_proximity_grid_unit and its testbench; depends on nothing.
package kpg_pkg;
    localparam int MAX_KEYS   = 64;
    localparam int GRID_COLS  = 10;
    localparam int GRID_ROWS  = 5;
    localparam int COORD_BITS = 12;
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int KEY_BITS   = $clog2(MAX_KEYS);
    localparam int CELL_BITS  = $clog2(CELL_COUNT);
    localparam int COL_BITS   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_BITS   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int LIMIT_BITS = 26;

    // Reciprocals for the ceiling division of the keyboard size by the grid size.
    // With a shift of 20 the product is exact for every dividend the registers can give.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_COLS  = ((1 << RECIP_SHIFT) + GRID_COLS - 1) / GRID_COLS;
    localparam int RECIP_ROWS  = ((1 << RECIP_SHIFT) + GRID_ROWS - 1) / GRID_ROWS;

    localparam logic [1:0] REG_KB_WIDTH  = 2'd0;
    localparam logic [1:0] REG_KB_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } key_rect_t;
endpackage

FILE: rtl/kpg_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; used for the key table and the cell mask store.
module kpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/key_proximity_grid_unit.sv
// Key proximity grid: key table load, grid rebuild and per-point query.
// A load gives no result. A query first rebuilds the grid if a load or a register write
// has cleared it, then gives one result per near key, or one not-found result, the last
// one with m_tlast; no new item is taken until that last result is taken. One item at a
// time. Synchronous active-low reset clears the key count, the grid state, the cell size
// and the configuration registers; the memories are not cleared.
module key_proximity_grid_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op
    input  logic        s_tuser,
    // key_left, key_top, key_w, key_h, query_x, query_y (lowest first)
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found
    output logic        m_tuser,
    // near_key (lowest first)
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CB = kpg_pkg::COORD_BITS;
    localparam int KB = kpg_pkg::KEY_BITS;
    localparam int CLB = kpg_pkg::CELL_BITS;
    localparam int SQ = 2 * (CB + 3);
    localparam int RS = kpg_pkg::RECIP_SHIFT;
    localparam int PW = CB + RS + 2;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_DIV = 4'd1, ST_CELL = 4'd2,
        ST_KRD = 4'd3, ST_KWAIT = 4'd4, ST_CORN = 4'd5, ST_MUL = 4'd6, ST_ACC = 4'd7,
        ST_CWR = 4'd8, ST_QLOC = 4'd9, ST_QRD = 4'd10, ST_QWAIT = 4'd11,
        ST_EMIT = 4'd12, ST_OUT = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [CB-1:0] kbw_reg, kbh_reg;
    logic [kpg_pkg::LIMIT_BITS-1:0] lim_reg;
    logic [KB:0] key_count_reg;
    logic grid_ready_reg;
    logic [CB-1:0] cell_w_reg, cell_h_reg;

    logic [CB-1:0] qx_reg, qy_reg;
    logic q_in_reg;
    logic [CB:0] drem_reg;
    logic [CB-1:0] dquo_reg;
    logic [3:0] dcnt_reg;
    logic dphase_reg;
    logic [kpg_pkg::COL_BITS-1:0] col_reg, qcol_reg;
    logic [kpg_pkg::ROW_BITS-1:0] row_reg, qrow_reg;
    logic [CB+5:0] x0_reg, y0_reg;
    logic [KB:0] ki_reg;
    logic [63:0] mask_reg;
    logic [1:0] corner_reg;
    logic mul_y_reg;
    logic signed [CB+2:0] kcx_reg, kcy_reg, dif_reg;
    logic [SQ-1:0] sum_reg;
    logic near_reg;
    logic [63:0] omask_reg;
    logic [7:0] out_data_reg;
    logic out_found_reg;
    logic out_last_reg;

    // Input fields
    logic in_op;
    kpg_pkg::key_rect_t in_key;
    logic signed [CB:0] in_qx, in_qy;
    assign in_op = s_tuser;
    assign in_key.left = s_tdata[11:0];
    assign in_key.top = s_tdata[23:12];
    assign in_key.w = s_tdata[35:24];
    assign in_key.h = s_tdata[47:36];
    assign in_qx = s_tdata[60:48];
    assign in_qy = s_tdata[73:61];

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser = out_found_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

    wire s_xfer = s_tvalid && s_tready;
    wire cfg_xfer = cfg_valid && cfg_ready;
    wire m_xfer = m_tvalid && m_tready;

    // Key table
    logic kt_we;
    logic [KB-1:0] kt_addr;
    kpg_pkg::key_rect_t kt_rdata;
    kpg_ram #(.WIDTH(4 * CB), .DEPTH(kpg_pkg::MAX_KEYS)) u_keys (
        .aclk(aclk), .we(kt_we), .addr(kt_addr), .wdata(in_key), .rdata(kt_rdata)
    );
    assign kt_we = s_xfer && (in_op == kpg_pkg::OP_LOAD) &&
                   (key_count_reg < (KB+1)'(kpg_pkg::MAX_KEYS));
    assign kt_addr = (state_reg == ST_IDLE) ? key_count_reg[KB-1:0] : ki_reg[KB-1:0];

    // Cell mask store
    logic cm_we;
    logic [CLB-1:0] cm_addr;
    logic [63:0] cm_rdata;
    logic [CLB+5:0] cell_lin, qcell_lin;
    assign cell_lin = (CLB+6)'(row_reg) * (CLB+6)'(kpg_pkg::GRID_COLS) + (CLB+6)'(col_reg);
    assign qcell_lin = (CLB+6)'(qrow_reg) * (CLB+6)'(kpg_pkg::GRID_COLS) + (CLB+6)'(qcol_reg);
    assign cm_we = (state_reg == ST_CWR);
    assign cm_addr = (state_reg == ST_CWR) ? cell_lin[CLB-1:0] : qcell_lin[CLB-1:0];
    kpg_ram #(.WIDTH(64), .DEPTH(kpg_pkg::CELL_COUNT)) u_cells (
        .aclk(aclk), .we(cm_we), .addr(cm_addr), .wdata(mask_reg), .rdata(cm_rdata)
    );

    // Cell size: ceiling division by the grid size through a reciprocal multiplication.
    logic [CB:0] w_num, h_num;
    logic [PW-1:0] w_prod, h_prod;
    assign w_num = {1'b0, kbw_reg} + (CB+1)'(kpg_pkg::GRID_COLS - 1);
    assign h_num = {1'b0, kbh_reg} + (CB+1)'(kpg_pkg::GRID_ROWS - 1);
    assign w_prod = PW'(w_num) * PW'(kpg_pkg::RECIP_COLS);
    assign h_prod = PW'(h_num) * PW'(kpg_pkg::RECIP_ROWS);

    // Shared restoring divider step for the query cell, shared adder for corners,
    // shared squarer.
    logic [CB:0] dtrial;
    assign dtrial = {drem_reg[CB-1:0], dquo_reg[CB-1]};
    logic [CB:0] ddiv;
    assign ddiv = dphase_reg ? {1'b0, cell_h_reg} : {1'b0, cell_w_reg};
    wire dge = dtrial >= ddiv;

    logic signed [CB+6:0] px, py;
    always_comb begin
        px = $signed({1'b0, x0_reg});
        py = $signed({1'b0, y0_reg});
        if (corner_reg == 2'd1 || corner_reg == 2'd2)
            px = px + $signed({7'b0, cell_w_reg}) - (CB+7)'(1);
        if (corner_reg[1]) py = py + $signed({7'b0, cell_h_reg}) - (CB+7)'(1);
    end
    logic signed [CB+6:0] dsel;
    assign dsel = mul_y_reg ? (CB+7)'(kcy_reg) - py : (CB+7)'(kcx_reg) - px;
    logic [SQ-1:0] sqr;
    assign sqr = SQ'(dif_reg * dif_reg);

    wire last_corner = (corner_reg == 2'd3);
    logic [63:0] lowbit;
    assign lowbit = omask_reg & (~omask_reg + 64'd1);
    logic [5:0] lowidx;
    always_comb begin
        lowidx = '0;
        for (int i = 63; i >= 0; i--) if (lowbit[i]) lowidx = 6'(i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kbw_reg <= '0; kbh_reg <= '0; lim_reg <= '0;
            key_count_reg <= '0; grid_ready_reg <= 1'b0;
            cell_w_reg <= '0; cell_h_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_xfer) begin
                unique case (cfg_index)
                    kpg_pkg::REG_KB_WIDTH:  begin kbw_reg <= cfg_data[CB-1:0]; grid_ready_reg <= 1'b0; end
                    kpg_pkg::REG_KB_HEIGHT: begin kbh_reg <= cfg_data[CB-1:0]; grid_ready_reg <= 1'b0; end
                    kpg_pkg::REG_LIMIT: begin
                        lim_reg <= cfg_data[kpg_pkg::LIMIT_BITS-1:0]; grid_ready_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (s_xfer && in_op == kpg_pkg::OP_LOAD) begin
                grid_ready_reg <= 1'b0;
                if (kt_we) key_count_reg <= key_count_reg + 1'b1;
            end
            if (state_reg == ST_DIV) begin
                cell_w_reg <= w_prod[RS +: CB];
                cell_h_reg <= h_prod[RS +: CB];
            end
            if (state_reg == ST_CWR && row_reg == (kpg_pkg::ROW_BITS)'(kpg_pkg::GRID_ROWS - 1) &&
                col_reg == (kpg_pkg::COL_BITS)'(kpg_pkg::GRID_COLS - 1))
                grid_ready_reg <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                qx_reg <= in_qx[CB-1:0];
                qy_reg <= in_qy[CB-1:0];
                q_in_reg <= !in_qx[CB] && !in_qy[CB] && (in_qx[CB-1:0] < kbw_reg) &&
                            (in_qy[CB-1:0] < kbh_reg);
                dphase_reg <= 1'b0;
                dcnt_reg <= 4'(CB);
                drem_reg <= '0;
                dquo_reg <= in_qx[CB-1:0];
                col_reg <= '0; row_reg <= '0;
            end
            ST_QLOC: begin
                if (dcnt_reg != 4'd0) begin
                    drem_reg <= dge ? dtrial - ddiv : dtrial;
                    dquo_reg <= {dquo_reg[CB-2:0], dge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                end else begin
                    if (dphase_reg) qrow_reg <= (kpg_pkg::ROW_BITS)'(dquo_reg);
                    else qcol_reg <= (kpg_pkg::COL_BITS)'(dquo_reg);
                    dphase_reg <= 1'b1;
                    dcnt_reg <= 4'(CB);
                    drem_reg <= '0;
                    dquo_reg <= qy_reg;
                end
            end
            ST_CELL: begin
                x0_reg <= (CB+6)'(col_reg) * (CB+6)'(cell_w_reg);
                y0_reg <= (CB+6)'(row_reg) * (CB+6)'(cell_h_reg);
                ki_reg <= '0;
                mask_reg <= '0;
            end
            ST_KWAIT: begin
                kcx_reg <= $signed({3'b0, kt_rdata.left}) + $signed({4'b0, kt_rdata.w[CB-1:1]});
                kcy_reg <= $signed({3'b0, kt_rdata.top}) + $signed({4'b0, kt_rdata.h[CB-1:1]});
                corner_reg <= 2'd0;
                mul_y_reg <= 1'b0;
                near_reg <= 1'b0;
            end
            ST_CORN: begin
                dif_reg <= (CB+3)'(dsel);
            end
            ST_MUL: begin
                if (!mul_y_reg) begin
                    sum_reg <= sqr;
                    mul_y_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_reg + sqr;
                end
            end
            ST_ACC: begin
                if (sum_reg < SQ'(lim_reg)) near_reg <= 1'b1;
                corner_reg <= corner_reg + 1'b1;
                mul_y_reg <= 1'b0;
                if (last_corner || sum_reg < SQ'(lim_reg)) begin
                    if (sum_reg < SQ'(lim_reg) || near_reg) mask_reg[ki_reg[KB-1:0]] <= 1'b1;
                    ki_reg <= ki_reg + 1'b1;
                end
            end
            ST_CWR: begin
                if (col_reg == (kpg_pkg::COL_BITS)'(kpg_pkg::GRID_COLS - 1)) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
                dphase_reg <= 1'b0;
                dcnt_reg <= 4'(CB);
                drem_reg <= '0;
                dquo_reg <= qx_reg;
            end
            ST_QWAIT: begin
                omask_reg <= (q_in_reg && cell_w_reg != '0 && cell_h_reg != '0 &&
                              qcell_lin < (CLB+6)'(kpg_pkg::CELL_COUNT)) ? cm_rdata : 64'd0;
            end
            ST_EMIT: begin
                if (omask_reg == 64'd0) begin
                    out_data_reg <= 8'd0;
                    out_found_reg <= 1'b0;
                    out_last_reg <= 1'b1;
                end else begin
                    out_data_reg <= {2'b0, lowidx};
                    out_found_reg <= 1'b1;
                    out_last_reg <= (omask_reg & ~lowbit) == 64'd0;
                    omask_reg <= omask_reg & ~lowbit;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_xfer && in_op == kpg_pkg::OP_QUERY) begin
                state_next = grid_ready_reg ? ST_QLOC : ST_DIV;
            end
            ST_DIV: state_next = ST_CELL;
            ST_CELL: state_next = ST_KRD;
            ST_KRD: state_next = (ki_reg == key_count_reg) ? ST_CWR : ST_KWAIT;
            ST_KWAIT: state_next = ST_CORN;
            ST_CORN: state_next = ST_MUL;
            ST_MUL: state_next = mul_y_reg ? ST_ACC : ST_CORN;
            ST_ACC: state_next = (last_corner || sum_reg < SQ'(lim_reg)) ? ST_KRD : ST_CORN;
            ST_CWR: state_next = (row_reg == (kpg_pkg::ROW_BITS)'(kpg_pkg::GRID_ROWS - 1) &&
                    col_reg == (kpg_pkg::COL_BITS)'(kpg_pkg::GRID_COLS - 1)) ? ST_QLOC : ST_CELL;
            ST_QLOC: if (dcnt_reg == 4'd0 && dphase_reg) state_next = ST_QRD;
            ST_QRD: state_next = ST_QWAIT;
            ST_QWAIT: state_next = ST_EMIT;
            ST_EMIT: state_next = ST_OUT;
            ST_OUT: if (m_xfer) state_next = out_last_reg ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("result changed while stalled");
    a_notfound_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("not-found result is not a lone last");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= (KB+1)'(kpg_pkg::MAX_KEYS))
        else $error("key count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken during output run");
`endif
endmodule
